/* design/mlp_pkg.sv */
`default_nettype none

package mlp_pkg;

  localparam int H = 15;
  localparam int HW_BASE = 0;
  localparam int HB_BASE = 2 * H;
  localparam int OW_BASE = 3 * H;
  localparam int OB_BASE = 5 * H;
  localparam int N_SLOTS = 5 * H + 2;
  localparam int SLOT_W = $clog2(N_SLOTS);
  localparam int HC_W = $clog2(H + 1);

  localparam int SIG_DEPTH = 256;
  localparam int SIG_IDX_W = $clog2(SIG_DEPTH);

  localparam logic [15:0] LR_RESET = 16'd328;

  typedef enum logic [1:0] {
    FN_LOAD   = 2'd0,
    FN_INFER  = 2'd1,
    FN_TRAIN  = 2'd2,
    FN_UPDATE = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FH,
    ST_FO_B0,
    ST_FO_B1,
    ST_FO_MAC,
    ST_FO_TAIL,
    ST_FO_SIG,
    ST_FO_E1,
    ST_FO_E2,
    ST_FO_D2,
    ST_FO_D3,
    ST_BO_A,
    ST_BO_B,
    ST_BH,
    ST_BH_GA,
    ST_BH_GB,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef logic [12:0] sig_lut_t [SIG_DEPTH];

  // exp(-2^(j-12)) in Q2.30
  localparam logic [31:0] EXP_K [16] = '{
    32'd1073479712, 32'd1073217664, 32'd1072693760, 32'd1071646719,
    32'd1069555701, 32'd1065385899, 32'd1057029464, 32'd1040706261,
    32'd1008687096, 32'd947573834,  32'd836230973,  32'd651257337,
    32'd395007542,  32'd145315154,  32'd19666268,   32'd360200
  };

  function automatic logic [12:0] sig_entry(int i);
    longint v;
    longint unsigned a;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    longint unsigned rem;
    longint unsigned q;
    v = ((2 * i + 1) * 32768) / SIG_DEPTH - 32768;
    a = (v < 0) ? longint'(-v) : longint'(v);
    e = 64'd1 << 30;
    for (int j = 0; j < 16; j++) begin
      if (a[j]) e = (e * EXP_K[j] + (64'd1 << 29)) >> 30;
    end
    num = (v >= 0) ? (64'd4096 << 30) : (64'd4096 * e);
    den = (64'd1 << 30) + e;
    num = num + (den >> 1);
    rem = 0;
    q = 0;
    // restoring divide, elaboration only
    for (int b = 47; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      if (rem >= den) begin
        rem = rem - den;
        q = q | (64'd1 << b);
      end
    end
    return q[12:0];
  endfunction

  function automatic sig_lut_t build_sig_lut();
    sig_lut_t t;
    for (int i = 0; i < SIG_DEPTH; i++) t[i] = sig_entry(i);
    return t;
  endfunction

  localparam sig_lut_t SIG_LUT = build_sig_lut();

  function automatic logic [12:0] sig_lookup(input logic signed [15:0] z);
    logic [15:0] u;
    u = z ^ 16'h8000;
    return SIG_LUT[u[15 -: SIG_IDX_W]];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [51:0] a);
    if (a > 52'sd32767) return 16'sh7fff;
    if (a < -52'sd32768) return 16'sh8000;
    return a[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] a);
    if (a > 52'sd2147483647) return 32'sh7fffffff;
    if (a < -52'sd2147483648) return 32'sh80000000;
    return a[31:0];
  endfunction

endpackage

`default_nettype wire

/* design/mlp_backprop_trainer.sv */
`default_nettype none

// Two-input, fifteen-hidden, two-output sigmoid network trainer. in_tuser carries the
// command: load one weight slot, infer, train one sample (gradients summed), or apply
// the summed gradients scaled by the learning rate and clear the sums. Every command
// returns one item; load and update return zeros. All products go through one shared
// 34x17 multiplier with a registered product, and weights sit in a one-read-port
// memory, so items are processed one at a time and update visits each weight slot
// in turn. Weights must be loaded before infer or train.
module mlp_backprop_trainer
  import mlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // x_first[15:0], x_second[31:16], target_first[44:32], target_second[57:45],
  // weight_index[64:58], weight_value[80:65], zero pad
  input  wire logic [87:0] in_tdata,
  // func[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // first_output[12:0], second_output[25:13], predicted_class[26],
  // sample_error[52:27], zero pad
  output logic [55:0]      out_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  state_t state_r, state_nxt;
  logic [2:0] sub_r, sub_nxt;
  logic [HC_W-1:0] hc_r, hc_nxt;
  logic kc_r, kc_nxt;
  logic [SLOT_W-1:0] ui_r, ui_nxt;
  func_t func_r, func_nxt;
  logic [15:0] lr_r;

  logic signed [15:0] x0_r, x1_r, x0_nxt, x1_nxt;
  logic [12:0] t0_r, t1_r, t0_nxt, t1_nxt;
  logic signed [39:0] acc_r, acc_nxt;
  logic [25:0] err_r, err_nxt;
  logic signed [27:0] dh_r, dh_nxt;
  logic out_tvalid_r, out_tvalid_nxt;
  logic [55:0] out_tdata_r, out_tdata_nxt;

  logic [12:0] y_r [2];
  logic signed [23:0] dout_r [2];
  logic [12:0] act_r [H];

  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [50:0] prod_r;

  logic signed [15:0] wmem [N_SLOTS];
  logic signed [15:0] w_rdata_r;
  logic [SLOT_W-1:0] w_raddr, w_waddr;
  logic w_we;
  logic signed [15:0] w_wdata;

  logic signed [31:0] gmem [N_SLOTS];
  logic signed [31:0] g_rdata_r;
  logic [N_SLOTS-1:0] gvalid_r;
  logic gv_rdata_r;
  logic [SLOT_W-1:0] g_addr;
  logic g_we, g_clr;
  logic signed [31:0] g_wdata;
  logic signed [31:0] gcur;

  logic act_we, y_we, dout_we;
  logic [12:0] act_wdata, y_wdata;
  logic [HC_W-1:0] act_idx;
  logic [12:0] act_sel, y_sel, t_sel;
  logic signed [13:0] diff;
  logic [SLOT_W-1:0] hc_ext;

  logic in_acc;
  logic [15:0] in_x_first, in_x_second, in_weight_value;
  logic [12:0] in_target_first, in_target_second;
  logic [6:0] in_weight_index;

  assign in_x_first       = in_tdata[15:0];
  assign in_x_second      = in_tdata[31:16];
  assign in_target_first  = in_tdata[44:32];
  assign in_target_second = in_tdata[57:45];
  assign in_weight_index  = in_tdata[64:58];
  assign in_weight_value  = in_tdata[80:65];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign hc_ext  = SLOT_W'(hc_r);
  assign act_sel = act_r[act_idx];
  assign y_sel   = y_r[kc_r];
  assign t_sel   = kc_r ? t1_r : t0_r;
  assign diff    = $signed({1'b0, y_sel}) - $signed({1'b0, t_sel});
  assign gcur    = gv_rdata_r ? g_rdata_r : 32'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sub_r        <= '0;
      hc_r         <= '0;
      kc_r         <= 1'b0;
      ui_r         <= '0;
      func_r       <= FN_LOAD;
      out_tvalid_r <= 1'b0;
      lr_r         <= LR_RESET;
      gvalid_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      sub_r        <= sub_nxt;
      hc_r         <= hc_nxt;
      kc_r         <= kc_nxt;
      ui_r         <= ui_nxt;
      func_r       <= func_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) lr_r <= cfg_wr_data;
      if (g_we) gvalid_r[g_addr] <= 1'b1;
      if (g_clr) gvalid_r[ui_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    x0_r        <= x0_nxt;
    x1_r        <= x1_nxt;
    t0_r        <= t0_nxt;
    t1_r        <= t1_nxt;
    acc_r       <= acc_nxt;
    err_r       <= err_nxt;
    dh_r        <= dh_nxt;
    out_tdata_r <= out_tdata_nxt;
    prod_r      <= mul_a * mul_b;
    if (act_we) act_r[hc_r] <= act_wdata;
    if (y_we) y_r[kc_r] <= y_wdata;
    if (dout_we) dout_r[kc_r] <= prod_r[23:0];
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    w_rdata_r <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (g_we) gmem[g_addr] <= g_wdata;
    g_rdata_r  <= gmem[g_addr];
    gv_rdata_r <= gvalid_r[g_addr];
  end

  always_comb begin
    logic signed [50:0] step;
    logic [12:0] omask;
    state_nxt      = state_r;
    sub_nxt        = sub_r;
    hc_nxt         = hc_r;
    kc_nxt         = kc_r;
    ui_nxt         = ui_r;
    func_nxt       = func_r;
    x0_nxt         = x0_r;
    x1_nxt         = x1_r;
    t0_nxt         = t0_r;
    t1_nxt         = t1_r;
    acc_nxt        = acc_r;
    err_nxt        = err_r;
    dh_nxt         = dh_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    mul_a          = '0;
    mul_b          = '0;
    w_raddr        = '0;
    w_waddr        = ui_r;
    w_we           = 1'b0;
    w_wdata        = '0;
    g_addr         = '0;
    g_we           = 1'b0;
    g_clr          = 1'b0;
    g_wdata        = '0;
    act_we         = 1'b0;
    act_wdata      = '0;
    act_idx        = hc_r;
    y_we           = 1'b0;
    y_wdata        = '0;
    dout_we        = 1'b0;
    step           = '0;
    omask          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          func_nxt = func_t'(in_tuser);
          x0_nxt   = in_x_first;
          x1_nxt   = in_x_second;
          t0_nxt   = (in_target_first > 13'd4096) ? 13'd4096 : in_target_first;
          t1_nxt   = (in_target_second > 13'd4096) ? 13'd4096 : in_target_second;
          sub_nxt  = '0;
          hc_nxt   = '0;
          kc_nxt   = 1'b0;
          ui_nxt   = '0;
          acc_nxt  = '0;
          err_nxt  = '0;
          unique case (func_t'(in_tuser))
            FN_LOAD: begin
              w_we      = (in_weight_index < 7'(N_SLOTS));
              w_waddr   = in_weight_index[SLOT_W-1:0];
              w_wdata   = in_weight_value;
              state_nxt = ST_DONE;
            end
            FN_UPDATE: state_nxt = ST_UPD;
            default:   state_nxt = ST_FH;
          endcase
        end
      end

      ST_FH: begin
        sub_nxt = sub_r + 3'd1;
        case (sub_r)
          3'd0: w_raddr = SLOT_W'(HB_BASE) + hc_ext;
          3'd1: begin
            acc_nxt = 40'(w_rdata_r) <<< 12;
            w_raddr = SLOT_W'(HW_BASE) + (hc_ext << 1);
          end
          3'd2: begin
            mul_a   = 34'(w_rdata_r);
            mul_b   = 17'(x0_r);
            w_raddr = SLOT_W'(HW_BASE) + (hc_ext << 1) + SLOT_W'(1);
          end
          3'd3: begin
            acc_nxt = acc_r + 40'(prod_r);
            mul_a   = 34'(w_rdata_r);
            mul_b   = 17'(x1_r);
          end
          3'd4: acc_nxt = acc_r + 40'(prod_r);
          default: begin
            act_we    = 1'b1;
            act_wdata = sig_lookup(sat16(52'(acc_r >>> 12)));
            sub_nxt   = '0;
            if (hc_r == HC_W'(H - 1)) begin
              kc_nxt    = 1'b0;
              state_nxt = ST_FO_B0;
            end else begin
              hc_nxt = hc_r + HC_W'(1);
            end
          end
        endcase
      end

      ST_FO_B0: begin
        w_raddr   = SLOT_W'(OB_BASE) + SLOT_W'(kc_r);
        state_nxt = ST_FO_B1;
      end

      ST_FO_B1: begin
        acc_nxt   = 40'(w_rdata_r) <<< 12;
        w_raddr   = SLOT_W'(OW_BASE) + (kc_r ? SLOT_W'(H) : '0);
        hc_nxt    = '0;
        state_nxt = ST_FO_MAC;
      end

      ST_FO_MAC: begin
        mul_a = 34'(w_rdata_r);
        mul_b = 17'(act_sel);
        if (hc_r != '0) acc_nxt = acc_r + 40'(prod_r);
        w_raddr = SLOT_W'(OW_BASE) + (kc_r ? SLOT_W'(H) : '0) + hc_ext + SLOT_W'(1);
        if (hc_r == HC_W'(H - 1)) state_nxt = ST_FO_TAIL;
        else hc_nxt = hc_r + HC_W'(1);
      end

      ST_FO_TAIL: begin
        acc_nxt   = acc_r + 40'(prod_r);
        state_nxt = ST_FO_SIG;
      end

      ST_FO_SIG: begin
        y_we      = 1'b1;
        y_wdata   = sig_lookup(sat16(52'(acc_r >>> 12)));
        state_nxt = ST_FO_E1;
      end

      ST_FO_E1: begin
        mul_a     = 34'(diff);
        mul_b     = 17'(diff);
        state_nxt = ST_FO_E2;
      end

      ST_FO_E2: begin
        err_nxt   = err_r + prod_r[25:0];
        mul_a     = 34'(y_sel);
        mul_b     = 17'(13'd4096 - y_sel);
        state_nxt = ST_FO_D2;
      end

      ST_FO_D2: begin
        // sig'(y) = y*(1-y), floor to Q0.12
        mul_a     = 34'(diff);
        mul_b     = $signed(prod_r[28:12]);
        state_nxt = ST_FO_D3;
      end

      ST_FO_D3: begin
        dout_we = 1'b1;
        if (kc_r) begin
          kc_nxt    = 1'b0;
          hc_nxt    = '0;
          state_nxt = (func_r == FN_TRAIN) ? ST_BO_A : ST_DONE;
        end else begin
          kc_nxt    = 1'b1;
          state_nxt = ST_FO_B0;
        end
      end

      ST_BO_A, ST_BO_B: begin
        if (hc_r == HC_W'(H)) g_addr = SLOT_W'(OB_BASE) + SLOT_W'(kc_r);
        else g_addr = SLOT_W'(OW_BASE) + (kc_r ? SLOT_W'(H) : '0) + hc_ext;
        if (state_r == ST_BO_A) begin
          mul_a     = 34'(dout_r[kc_r]);
          mul_b     = (hc_r == HC_W'(H)) ? 17'sd4096 : 17'(act_sel);
          state_nxt = ST_BO_B;
        end else begin
          g_we      = 1'b1;
          g_wdata   = sat32(52'(gcur) + 52'(prod_r >>> 12));
          state_nxt = ST_BO_A;
          if (hc_r == HC_W'(H)) begin
            hc_nxt = '0;
            if (kc_r) begin
              sub_nxt   = '0;
              state_nxt = ST_BH;
            end else begin
              kc_nxt = 1'b1;
            end
          end else begin
            hc_nxt = hc_r + HC_W'(1);
          end
        end
      end

      ST_BH: begin
        sub_nxt = sub_r + 3'd1;
        case (sub_r)
          3'd0: w_raddr = SLOT_W'(OW_BASE) + hc_ext;
          3'd1: begin
            w_raddr = SLOT_W'(OW_BASE + H) + hc_ext;
            mul_a   = 34'(dout_r[0]);
            mul_b   = 17'(w_rdata_r);
          end
          3'd2: begin
            acc_nxt = 40'(prod_r);
            mul_a   = 34'(dout_r[1]);
            mul_b   = 17'(w_rdata_r);
          end
          3'd3: begin
            acc_nxt = acc_r + 40'(prod_r);
            mul_a   = 34'(act_sel);
            mul_b   = 17'(13'd4096 - act_sel);
          end
          3'd4: begin
            mul_a = 34'(acc_r >>> 12);
            mul_b = $signed(prod_r[28:12]);
          end
          default: begin
            dh_nxt    = 28'(prod_r >>> 12);
            sub_nxt   = '0;
            state_nxt = ST_BH_GA;
          end
        endcase
      end

      ST_BH_GA, ST_BH_GB: begin
        if (sub_r == 3'd2) g_addr = SLOT_W'(HB_BASE) + hc_ext;
        else g_addr = SLOT_W'(HW_BASE) + (hc_ext << 1) + SLOT_W'(sub_r[0]);
        if (state_r == ST_BH_GA) begin
          mul_a = 34'(dh_r);
          case (sub_r)
            3'd0:    mul_b = 17'(x0_r);
            3'd1:    mul_b = 17'(x1_r);
            default: mul_b = 17'sd4096;
          endcase
          state_nxt = ST_BH_GB;
        end else begin
          g_we      = 1'b1;
          g_wdata   = sat32(52'(gcur) + 52'(prod_r >>> 12));
          state_nxt = ST_BH_GA;
          if (sub_r == 3'd2) begin
            sub_nxt = '0;
            if (hc_r == HC_W'(H - 1)) state_nxt = ST_DONE;
            else begin
              hc_nxt    = hc_r + HC_W'(1);
              state_nxt = ST_BH;
            end
          end else begin
            sub_nxt = sub_r + 3'd1;
          end
        end
      end

      ST_UPD: begin
        w_raddr = ui_r;
        g_addr  = ui_r;
        sub_nxt = sub_r + 3'd1;
        case (sub_r)
          3'd0: ;
          3'd1: begin
            mul_a = 34'(gcur);
            mul_b = $signed({1'b0, lr_r});
          end
          default: begin
            // round half up, floor shift by 28
            step    = (prod_r + 51'sd134217728) >>> 28;
            w_we    = 1'b1;
            w_waddr = ui_r;
            w_wdata = sat16(52'(w_rdata_r) - 52'(step));
            g_clr   = 1'b1;
            sub_nxt = '0;
            if (ui_r == SLOT_W'(N_SLOTS - 1)) state_nxt = ST_DONE;
            else ui_nxt = ui_r + SLOT_W'(1);
          end
        endcase
      end

      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          omask = (func_r == FN_INFER || func_r == FN_TRAIN) ? 13'h1fff : 13'h0;
          out_tdata_nxt = {3'b000,
                           err_r & {26{omask[0]}},
                           (y_r[1] > y_r[0]) & omask[0],
                           y_r[1] & omask,
                           y_r[0] & omask};
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) && (func_r == FN_LOAD || func_r == FN_UPDATE) |-> out_tdata_r == '0)
    else $error("load or update returned nonzero result");

  a_hc_range: assert property (@(posedge clk) disable iff (!rst_n)
    hc_r <= HC_W'(H))
    else $error("unit counter out of range");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> err_r <= 26'd33554432)
    else $error("sample error exceeds two squared full scales");

  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD && sub_r == 3'd2 |=> !gvalid_r[$past(ui_r)])
    else $error("gradient sum not cleared after update");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("accepted item did not start");

endmodule

`default_nettype wire
